[hw/rtl/desu_pkg.sv]
// shared types and constants for the der ecdsa signature unpacker
package desu_pkg;

    // der tags and the long-form length flag
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] LEN_LONG_BIT = 8'h80;

    // result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_SEQ_TAG  = 3'd1;
    localparam logic [2:0] ST_LONG_LEN     = 3'd2;
    localparam logic [2:0] ST_LEN_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_BAD_INT_TAG  = 3'd4;
    localparam logic [2:0] ST_TRUNCATED    = 3'd5;

    // parser phases, one-hot
    typedef enum logic [7:0] {
        PH_SEQ_TAG = 8'b0000_0001,
        PH_SEQ_LEN = 8'b0000_0010,
        PH_R_TAG   = 8'b0000_0100,
        PH_R_LEN   = 8'b0000_1000,
        PH_R_BODY  = 8'b0001_0000,
        PH_S_TAG   = 8'b0010_0000,
        PH_S_LEN   = 8'b0100_0000,
        PH_S_BODY  = 8'b1000_0000
    } t_phase;

endpackage

[hw/rtl/der_ecdsa_signature_unpack_top.sv]
// der ecdsa signature unpacker: der sequence of two integers to raw r||s words
//
// Input channel (i_valid / o_stall): one byte of the der signature per request,
// with the total encoded length on every byte and i_frame_end on the last byte.
// Output channel (o_valid / i_stall): on each frame end the block gives either
// SIG_WORDS requests of 64 bits holding r||s (first byte most significant), or a
// single request with a zero word and the error code in o_status. o_burst_end
// marks the last request of a signature.
// Throughput: one byte per cycle while o_stall is low. An accepted byte is held
// in the input register and then steps the parser; the step of a frame-end byte
// also loads the output word buffer, from which the first result is offered.
// The buffer drains one word per cycle while i_stall is low; a frame-end byte
// waits in the input register (o_stall high) while the buffer still holds more
// than one word or its last word is stalled, so signatures shorter than
// SIG_WORDS bytes are limited by the output rate.
// Reset clears the parser, the input register and the output buffer count;
// no results are pending afterwards. When the receiver stalls, the current word
// holds and input bytes keep flowing until a frame end meets the busy buffer.
module der_ecdsa_signature_unpack_top
    import desu_pkg::*;
#(
    parameter int COORD_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_total_length,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_sig_word,
    output logic [2:0]  o_status,
    output logic        o_burst_end
);

    localparam int CoordW   = COORD_BYTES * 8;
    localparam int SigBytes = 2 * COORD_BYTES;
    localparam int SigWords = (SigBytes + 7) / 8;
    localparam int BufW     = SigWords * 64;
    localparam int PadBits  = BufW - SigBytes * 8;
    localparam int CntW     = $clog2(SigWords + 1);

    // input register
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic [7:0]        r_in_total;
    logic              r_in_fe;

    // parser state
    t_phase            r_phase, n_phase;
    logic [7:0]        r_left, n_left;
    logic [7:0]        r_pos, n_pos;
    logic [2:0]        r_err, n_err;
    logic [CoordW-1:0] r_shift, n_shift;
    logic [CoordW-1:0] r_saved, n_saved;

    // output word buffer
    logic [BufW-1:0]   r_ob_data;
    logic [2:0]        r_ob_status;
    logic [CntW-1:0]   r_ob_cnt;

    logic              ob_free;
    logic              fire;
    logic              pop;
    logic              in_accept;
    logic              complete;
    logic              n_complete;
    logic [2:0]        fin_err;
    logic [BufW-1:0]   packed_sig;

    // handshake and flow control
    assign o_valid   = (r_ob_cnt != '0);
    assign pop       = o_valid && !i_stall;
    assign ob_free   = (r_ob_cnt == '0) || ((r_ob_cnt == CntW'(1)) && !i_stall);
    assign fire      = r_in_valid && (!r_in_fe || ob_free);
    assign o_stall   = r_in_valid && !fire;
    assign in_accept = i_valid && !o_stall;

    assign o_sig_word  = r_ob_data[BufW-1 -: 64];
    assign o_status    = r_ob_status;
    assign o_burst_end = (r_ob_cnt == CntW'(1));

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte  <= i_data_byte;
            r_in_total <= i_total_length;
            r_in_fe    <= i_frame_end;
        end
    end

    // per-byte parser step
    assign complete = (r_phase == PH_S_BODY) && (r_left == '0);

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_pos   = r_pos;
        n_err   = r_err;
        n_shift = r_shift;
        n_saved = r_saved;
        if (r_err == ST_OK && !complete) begin
            if (r_pos >= r_in_total) begin
                n_err = ST_TRUNCATED;
            end else begin
                case (r_phase)
                    PH_SEQ_TAG: begin
                        if (r_in_byte != TAG_SEQUENCE) n_err = ST_BAD_SEQ_TAG;
                        else n_phase = PH_SEQ_LEN;
                    end
                    PH_SEQ_LEN: begin
                        if ((r_in_byte & LEN_LONG_BIT) != '0) begin
                            n_err = ST_LONG_LEN;
                        end else if (({1'b0, r_in_byte} + 9'd2) > {1'b0, r_in_total}) begin
                            n_err = ST_LEN_OVERFLOW;
                        end else begin
                            n_phase = PH_R_TAG;
                        end
                    end
                    PH_R_TAG, PH_S_TAG: begin
                        if (r_in_byte != TAG_INTEGER) n_err = ST_BAD_INT_TAG;
                        else n_phase = (r_phase == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
                    end
                    PH_R_LEN: begin
                        n_shift = '0;
                        n_left  = r_in_byte;
                        if (r_in_byte != '0) begin
                            n_phase = PH_R_BODY;
                        end else begin
                            n_saved = '0;
                            n_phase = PH_S_TAG;
                        end
                    end
                    PH_R_BODY: begin
                        n_shift = {r_shift[CoordW-9:0], r_in_byte};
                        n_left  = r_left - 8'd1;
                        if (r_left == 8'd1) begin
                            n_saved = n_shift;
                            n_phase = PH_S_TAG;
                        end
                    end
                    PH_S_LEN: begin
                        n_shift = '0;
                        n_left  = r_in_byte;
                        n_phase = PH_S_BODY;
                    end
                    PH_S_BODY: begin
                        n_shift = {r_shift[CoordW-9:0], r_in_byte};
                        n_left  = r_left - 8'd1;
                    end
                    default: begin
                        n_phase = PH_SEQ_TAG;
                    end
                endcase
            end
        end
        if (r_pos != 8'hFF) n_pos = r_pos + 8'd1;
    end

    // frame-end verdict and packed r||s
    assign n_complete = (n_phase == PH_S_BODY) && (n_left == '0);
    assign fin_err    = (n_err == ST_OK && !n_complete) ? ST_TRUNCATED : n_err;
    assign packed_sig = BufW'({n_saved, n_shift}) << PadBits;

    // parser control state, back to start after each frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEQ_TAG;
            r_left  <= '0;
            r_pos   <= '0;
            r_err   <= ST_OK;
        end else if (fire) begin
            if (r_in_fe) begin
                r_phase <= PH_SEQ_TAG;
                r_left  <= '0;
                r_pos   <= '0;
                r_err   <= ST_OK;
            end else begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_pos   <= n_pos;
                r_err   <= n_err;
            end
        end
    end

    // integer registers, always rewritten before use
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_shift <= n_shift;
            r_saved <= n_saved;
        end
    end

    // output buffer count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt <= '0;
        end else if (fire && r_in_fe) begin
            r_ob_cnt <= (fin_err != ST_OK) ? CntW'(1) : CntW'(SigWords);
        end else if (pop) begin
            r_ob_cnt <= r_ob_cnt - CntW'(1);
        end
    end

    // output buffer words, shifted out from the top
    always_ff @(posedge i_clk) begin
        if (fire && r_in_fe) begin
            r_ob_data   <= (fin_err != ST_OK) ? '0 : packed_sig;
            r_ob_status <= fin_err;
        end else if (pop) begin
            r_ob_data <= r_ob_data << 64;
        end
    end

`ifndef NO_ASSERTIONS
    a_err_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_sig_word == '0 && o_burst_end))
        else $error("error result is not a single zero word");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt <= CntW'(SigWords))
        else $error("output word count beyond burst length");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_in_fe && o_valid))
        else $error("input stalled without a waiting frame end");

    a_reset_phase: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == PH_SEQ_TAG && r_ob_cnt == '0))
        else $error("parser or buffer not cleared by reset");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_fe) |=> (r_phase == PH_SEQ_TAG && r_err == ST_OK && o_valid))
        else $error("frame end did not restart parser and load results");
`endif

endmodule
